/* sv/crt_pkg.sv */
`default_nettype none
package crt_pkg;

	localparam int WORD_BITS = 64;
	localparam int DW = 64;
	localparam int FW = 63;
	localparam int CNT_W = $clog2(DW);
	localparam logic [DW-1:0] MOD_MAX = (DW'(1) << (WORD_BITS - 1)) - DW'(1);
	localparam logic [DW-1:0] ALL_ONES = '1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_CONTRA = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	// datapath operations
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD = 5'd1;
	localparam logic [OP_W-1:0] OP_SET_F1 = 5'd2;
	localparam logic [OP_W-1:0] OP_SET_F2 = 5'd3;
	localparam logic [OP_W-1:0] OP_RED = 5'd4;
	localparam logic [OP_W-1:0] OP_GCD_INIT = 5'd5;
	localparam logic [OP_W-1:0] OP_GCD_DIV = 5'd6;
	localparam logic [OP_W-1:0] OP_GCD_STEP = 5'd7;
	localparam logic [OP_W-1:0] OP_DIFF = 5'd8;
	localparam logic [OP_W-1:0] OP_A1 = 5'd9;
	localparam logic [OP_W-1:0] OP_N = 5'd10;
	localparam logic [OP_W-1:0] OP_OVF = 5'd11;
	localparam logic [OP_W-1:0] OP_DM = 5'd12;
	localparam logic [OP_W-1:0] OP_INV0 = 5'd13;
	localparam logic [OP_W-1:0] OP_EU_INIT = 5'd14;
	localparam logic [OP_W-1:0] OP_EU_DIV = 5'd15;
	localparam logic [OP_W-1:0] OP_EU_MUL = 5'd16;
	localparam logic [OP_W-1:0] OP_EU_UPD = 5'd17;
	localparam logic [OP_W-1:0] OP_K = 5'd18;
	localparam logic [OP_W-1:0] OP_RES = 5'd19;
	localparam logic [OP_W-1:0] OP_MODS = 5'd20;
	localparam logic [OP_W-1:0] OP_COMMIT = 5'd21;
	localparam logic [OP_W-1:0] OP_OUT = 5'd22;

	typedef struct packed {
		logic div_done;
		logic mul_done;
		logic skip;
		logic m2_big;
		logic gcd_b_zero;
		logic rem_nz;
		logic ovf;
		logic eu_zero;
	} crt_sts_t;

endpackage
`default_nettype wire

/* sv/crt_div.sv */
`default_nettype none
module crt_div import crt_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic      [DW-1:0] quot,
	output logic      [DW-1:0] rem,
	output logic               done
);
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    quot_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [DW:0]      shifted;
	logic [DW:0]      diff;
	logic             ge;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, quot_q[DW-1]};
	assign ge = shifted >= {1'b0, dvs_q};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quot_q <= {quot_q[DW-2:0], ge};
		end
	end

	assign quot = quot_q;
	assign rem = rem_q;
	assign done = done_q;
endmodule
`default_nettype wire

/* sv/crt_mulmod.sv */
`default_nettype none
module crt_mulmod import crt_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] a,
	input  wire logic [DW-1:0] b,
	input  wire logic [DW-1:0] n,
	output logic      [DW-1:0] prod,
	output logic               done
);
	logic          busy_q;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] a_q;
	logic [DW-1:0] b_q;
	logic [DW-1:0] n_q;
	logic [DW:0]   sum_acc;
	logic [DW:0]   sum_dbl;
	logic [DW-1:0] acc_nx;
	logic [DW-1:0] a_nx;

	// shift and add, one multiplier bit per cycle; n all ones gives the product modulo all ones
	assign sum_acc = {1'b0, acc_q} + {1'b0, a_q};
	assign sum_dbl = {1'b0, a_q} + {1'b0, a_q};
	assign acc_nx = (sum_acc >= {1'b0, n_q}) ? DW'(sum_acc - {1'b0, n_q}) : sum_acc[DW-1:0];
	assign a_nx = (sum_dbl >= {1'b0, n_q}) ? DW'(sum_dbl - {1'b0, n_q}) : sum_dbl[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= a;
			b_q <= b;
			n_q <= n;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_nx;
			end
			a_q <= a_nx;
			b_q <= {1'b0, b_q[DW-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = busy_q && b_q == '0;
endmodule
`default_nettype wire

/* sv/crt_dp.sv */
`default_nettype none
module crt_dp import crt_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [OP_W-1:0] op,
	input  wire logic            start_new,
	input  wire logic [DW-1:0]   remainder,
	input  wire logic [FW-1:0]   modulus,
	output crt_sts_t             sts,
	output logic      [FW-1:0]   result_remainder,
	output logic      [FW-1:0]   result_modulus,
	output logic      [1:0]      status
);
	// running system
	logic [FW-1:0] r1_q;
	logic [FW-1:0] m1_q;
	logic [1:0]    fail_q;
	// item and work registers
	logic [DW-1:0] raw_q;
	logic [FW-1:0] m2_q;
	logic [DW-1:0] r2_q;
	logic [DW-1:0] ga_q;
	logic [DW-1:0] gb_q;
	logic [DW-1:0] qd_q;
	logic [DW-1:0] a1_q;
	logic [DW-1:0] nn_q;
	logic [DW-1:0] dm_q;
	logic [DW-1:0] r0_q;
	logic [DW-1:0] er1_q;
	logic [DW-1:0] t0_q;
	logic [DW-1:0] t1_q;
	logic [DW-1:0] tmp_q;
	logic [FW-1:0] out_rem_q;
	logic [FW-1:0] out_mod_q;
	logic [1:0]    out_sts_q;

	logic          div_start;
	logic [DW-1:0] div_a;
	logic [DW-1:0] div_b;
	logic [DW-1:0] div_quot;
	logic [DW-1:0] div_rem;
	logic          div_done;
	logic          mul_start;
	logic [DW-1:0] mul_a;
	logic [DW-1:0] mul_b;
	logic [DW-1:0] mul_n;
	logic [DW-1:0] mul_prod;
	logic          mul_done;

	logic [DW-1:0] m2_x;
	logic [DW-1:0] r1_x;
	logic [DW-1:0] mag;
	logic          dneg;
	logic [DW-1:0] dabs;
	logic [DW-1:0] qq;
	logic [DW-1:0] nt;

	assign m2_x = {1'b0, m2_q};
	assign r1_x = {1'b0, r1_q};
	assign mag = raw_q[DW-1] ? (~raw_q + DW'(1)) : raw_q;
	assign dneg = r2_q < r1_x;
	assign dabs = dneg ? (r1_x - r2_q) : (r2_q - r1_x);
	assign qq = (div_quot >= nn_q) ? (div_quot - nn_q) : div_quot;
	assign nt = (t0_q >= mul_prod) ? (t0_q - mul_prod) : (t0_q + nn_q - mul_prod);

	always_comb begin
		div_start = 1'b1;
		div_a = '0;
		div_b = '0;
		unique case (op)
			OP_RED: begin
				div_a = mag;
				div_b = m2_x;
			end
			OP_GCD_DIV: begin
				div_a = ga_q;
				div_b = gb_q;
			end
			OP_DIFF: begin
				div_a = dabs;
				div_b = ga_q;
			end
			OP_A1: begin
				div_a = {1'b0, m1_q};
				div_b = ga_q;
			end
			OP_N: begin
				div_a = m2_x;
				div_b = ga_q;
			end
			OP_OVF: begin
				div_a = MOD_MAX;
				div_b = m2_x;
			end
			OP_DM: begin
				div_a = qd_q;
				div_b = nn_q;
			end
			OP_INV0: begin
				div_a = a1_q;
				div_b = nn_q;
			end
			OP_EU_DIV: begin
				div_a = r0_q;
				div_b = er1_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	always_comb begin
		mul_start = 1'b1;
		mul_a = '0;
		mul_b = '0;
		mul_n = ALL_ONES;
		unique case (op)
			OP_EU_MUL: begin
				mul_a = qq;
				mul_b = t1_q;
				mul_n = nn_q;
			end
			OP_K: begin
				mul_a = dm_q;
				mul_b = t0_q;
				mul_n = nn_q;
			end
			OP_RES: begin
				mul_a = {1'b0, m1_q};
				mul_b = mul_prod;
			end
			OP_MODS: begin
				mul_a = a1_q;
				mul_b = m2_x;
			end
			default: mul_start = 1'b0;
		endcase
	end

	crt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.quot     (div_quot),
		.rem      (div_rem),
		.done     (div_done)
	);

	crt_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.n      (mul_n),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r1_q <= '0;
			m1_q <= FW'(1);
			fail_q <= ST_OK;
		end else begin
			unique case (op)
				OP_LOAD: begin
					if (start_new) begin
						r1_q <= '0;
						m1_q <= FW'(1);
						fail_q <= ST_OK;
					end
				end
				OP_SET_F1: fail_q <= ST_CONTRA;
				OP_SET_F2: fail_q <= ST_OVF;
				OP_COMMIT: begin
					r1_q <= tmp_q[FW-1:0];
					m1_q <= mul_prod[FW-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				raw_q <= remainder;
				m2_q <= modulus;
			end
			OP_GCD_INIT: begin
				if (raw_q[DW-1]) begin
					r2_q <= (div_rem == '0) ? '0 : (m2_x - div_rem);
				end else begin
					r2_q <= div_rem;
				end
				ga_q <= {1'b0, m1_q};
				gb_q <= m2_x;
			end
			OP_GCD_STEP: begin
				ga_q <= gb_q;
				gb_q <= div_rem;
			end
			OP_A1: qd_q <= div_quot;
			OP_N: a1_q <= div_quot;
			OP_OVF: nn_q <= div_quot;
			OP_INV0: dm_q <= (dneg && div_rem != '0) ? (nn_q - div_rem) : div_rem;
			OP_EU_INIT: begin
				r0_q <= nn_q;
				er1_q <= div_rem;
				t0_q <= '0;
				t1_q <= (nn_q == DW'(1)) ? '0 : DW'(1);
			end
			OP_EU_MUL: begin
				r0_q <= er1_q;
				er1_q <= div_rem;
			end
			OP_EU_UPD: begin
				t0_q <= t1_q;
				t1_q <= nt;
			end
			OP_MODS: tmp_q <= r1_x + mul_prod;
			OP_OUT: begin
				out_rem_q <= (fail_q != ST_OK) ? '0 : r1_q;
				out_mod_q <= (fail_q != ST_OK) ? '0 : m1_q;
				out_sts_q <= fail_q;
			end
			default: ;
		endcase
	end

	assign sts.div_done = div_done;
	assign sts.mul_done = mul_done;
	assign sts.skip = (fail_q != ST_OK) || (m2_q == '0);
	assign sts.m2_big = m2_x > MOD_MAX;
	assign sts.gcd_b_zero = gb_q == '0;
	assign sts.rem_nz = div_rem != '0;
	assign sts.ovf = a1_q > div_quot;
	assign sts.eu_zero = er1_q == '0;

	assign result_remainder = out_rem_q;
	assign result_modulus = out_mod_q;
	assign status = out_sts_q;
endmodule
`default_nettype wire

/* sv/crt_ctrl.sv */
`default_nettype none
module crt_ctrl import crt_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	input  wire crt_sts_t        sts,
	output logic      [OP_W-1:0] op
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_CHECK = 5'd1;
	localparam logic [4:0] S_W_RED = 5'd2;
	localparam logic [4:0] S_GCD = 5'd3;
	localparam logic [4:0] S_W_GCD = 5'd4;
	localparam logic [4:0] S_W_DIFF = 5'd5;
	localparam logic [4:0] S_W_A1 = 5'd6;
	localparam logic [4:0] S_W_N = 5'd7;
	localparam logic [4:0] S_W_OVF = 5'd8;
	localparam logic [4:0] S_W_DM = 5'd9;
	localparam logic [4:0] S_W_INV = 5'd10;
	localparam logic [4:0] S_EU = 5'd11;
	localparam logic [4:0] S_W_EUD = 5'd12;
	localparam logic [4:0] S_W_EUM = 5'd13;
	localparam logic [4:0] S_W_K = 5'd14;
	localparam logic [4:0] S_W_RES = 5'd15;
	localparam logic [4:0] S_W_MOD = 5'd16;
	localparam logic [4:0] S_OUT = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_nx;
	logic       m_tvalid_q;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_nx = state_q;
		op = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op = OP_LOAD;
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.skip) begin
					state_nx = S_OUT;
				end else if (sts.m2_big) begin
					op = OP_SET_F2;
					state_nx = S_OUT;
				end else begin
					op = OP_RED;
					state_nx = S_W_RED;
				end
			end
			S_W_RED: begin
				if (sts.div_done) begin
					op = OP_GCD_INIT;
					state_nx = S_GCD;
				end
			end
			S_GCD: begin
				if (sts.gcd_b_zero) begin
					op = OP_DIFF;
					state_nx = S_W_DIFF;
				end else begin
					op = OP_GCD_DIV;
					state_nx = S_W_GCD;
				end
			end
			S_W_GCD: begin
				if (sts.div_done) begin
					op = OP_GCD_STEP;
					state_nx = S_GCD;
				end
			end
			S_W_DIFF: begin
				if (sts.div_done) begin
					if (sts.rem_nz) begin
						op = OP_SET_F1;
						state_nx = S_OUT;
					end else begin
						op = OP_A1;
						state_nx = S_W_A1;
					end
				end
			end
			S_W_A1: begin
				if (sts.div_done) begin
					op = OP_N;
					state_nx = S_W_N;
				end
			end
			S_W_N: begin
				if (sts.div_done) begin
					op = OP_OVF;
					state_nx = S_W_OVF;
				end
			end
			S_W_OVF: begin
				if (sts.div_done) begin
					if (sts.ovf) begin
						op = OP_SET_F2;
						state_nx = S_OUT;
					end else begin
						op = OP_DM;
						state_nx = S_W_DM;
					end
				end
			end
			S_W_DM: begin
				if (sts.div_done) begin
					op = OP_INV0;
					state_nx = S_W_INV;
				end
			end
			S_W_INV: begin
				if (sts.div_done) begin
					op = OP_EU_INIT;
					state_nx = S_EU;
				end
			end
			S_EU: begin
				if (sts.eu_zero) begin
					op = OP_K;
					state_nx = S_W_K;
				end else begin
					op = OP_EU_DIV;
					state_nx = S_W_EUD;
				end
			end
			S_W_EUD: begin
				if (sts.div_done) begin
					op = OP_EU_MUL;
					state_nx = S_W_EUM;
				end
			end
			S_W_EUM: begin
				if (sts.mul_done) begin
					op = OP_EU_UPD;
					state_nx = S_EU;
				end
			end
			S_W_K: begin
				if (sts.mul_done) begin
					op = OP_RES;
					state_nx = S_W_RES;
				end
			end
			S_W_RES: begin
				if (sts.mul_done) begin
					op = OP_MODS;
					state_nx = S_W_MOD;
				end
			end
			S_W_MOD: begin
				if (sts.mul_done) begin
					op = OP_COMMIT;
					state_nx = S_OUT;
				end
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					op = OP_OUT;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (op == OP_OUT) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_CHECK)
		else $error("accepted word did not enter check");

	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_OUT)
		else $error("result word raised outside output state");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_W_RED || state_q == S_W_GCD || state_q == S_W_DIFF ||
			state_q == S_W_A1 || state_q == S_W_N || state_q == S_W_OVF ||
			state_q == S_W_DM || state_q == S_W_INV || state_q == S_W_EUD)
		else $error("divider finished while not awaited");

	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> state_q == S_W_EUM || state_q == S_W_K || state_q == S_W_RES ||
			state_q == S_W_MOD)
		else $error("multiplier finished while not awaited");
endmodule
`default_nettype wire

/* sv/crt_congruence_merger.sv */
// an item that is not merged (failure held, zero modulus) goes from the check straight to
// output, and the input is ready again in the same cycle that its result word is raised
// a merge reduces the remainder, runs the gcd of the moduli, checks consistency and overflow,
// finds the modular inverse and forms the new residue and modulus, all on one shared
// divider and one shift-add multiplier; one item at a time, a held result stalls it
// reset (arst_n low) clears running residue to 0, running modulus to 1, status consistent
`default_nettype none
module crt_congruence_merger import crt_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // remainder[63:0], modulus[126:64], zero pad
	input  wire logic [0:0]   s_tuser,  // start_new
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [127:0] m_tdata,  // result_remainder[62:0], result_modulus[125:63], pad
	output logic      [1:0]   m_tuser   // status
);
	crt_sts_t        sts;
	logic [OP_W-1:0] op;
	logic [FW-1:0]   res_rem;
	logic [FW-1:0]   res_mod;

	crt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.op       (op)
	);

	crt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.start_new        (s_tuser[0]),
		.remainder        (s_tdata[63:0]),
		.modulus          (s_tdata[126:64]),
		.sts              (sts),
		.result_remainder (res_rem),
		.result_modulus   (res_mod),
		.status           (m_tuser)
	);

	assign m_tdata = {2'b00, res_mod, res_rem};
endmodule
`default_nettype wire
